// ===== hw/rtl/c_directive_scanner_defines.svh =====
// assertion macros for the scanner checker
`ifndef C_DIRECTIVE_SCANNER_DEFINES_SVH
`define C_DIRECTIVE_SCANNER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CDS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CDS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/cds_pkg.sv =====
package cds_pkg;

	// counter widths
	localparam int POSITION_BITS = 32;
	localparam int LENGTH_BITS   = 16;

	// request field widths
	localparam int BYTE_W   = 8;
	localparam int KIND_W   = 2;
	localparam int START_W  = 32;
	localparam int LENGTH_W = 16;

	// event kinds
	localparam logic [KIND_W-1:0] KIND_QUOTED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ANGLE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WORD   = 2'd2;

	// shortest reported word: CONF_ plus one character
	localparam logic [LENGTH_W-1:0] WORD_MIN_LEN = 16'd6;
	// earliest first name byte of an include: after #include and the opening quote or angle bracket
	localparam logic [START_W-1:0] INC_MIN_START = 32'd9;

	// punctuation
	localparam logic [BYTE_W-1:0] CH_POUND  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2f;
	localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2a;
	localparam logic [BYTE_W-1:0] CH_NL     = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
	localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CH_LT     = 8'h3c;
	localparam logic [BYTE_W-1:0] CH_GT     = 8'h3e;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5f;

endpackage

// ===== hw/rtl/cds_ifs.sv =====
// source byte channel
interface cds_chars_if
	import cds_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

// name event channel
interface cds_events_if
	import cds_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   event_kind;
	logic [START_W-1:0]  name_start;
	logic [LENGTH_W-1:0] name_length;

	modport source (output valid, event_kind, name_start, name_length, input ready);
	modport sink   (input valid, event_kind, name_start, name_length, output ready);
endinterface

// configuration write channel
interface cds_cfg_if;
	logic valid;
	logic ready;
	logic suppress_conf;

	modport source (output valid, suppress_conf, input ready);
	modport sink   (input valid, suppress_conf, output ready);
endinterface

// ===== hw/rtl/c_directive_scanner.sv =====
// an accepted byte passes the byte stage and then the result register before its event is offered
// throughput: one byte per cycle, set by the single-cycle scan state update
// a blocked events channel holds the byte stage until the event is taken
// arst_n clears scan state, byte position, mark, length, config and valids
// the last_byte flag returns the scanner to its reset state, config kept
module c_directive_scanner
	import cds_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	cds_chars_if.sink           chars,
	cds_events_if.source        events,
	cds_cfg_if.sink             cfg
);

	typedef enum logic [5:0] {
		S_START, S_SLASH, S_LINE, S_LINE_ESC, S_BLOCK, S_BLOCK_STAR,
		S_SQ, S_SQ_ESC, S_DQ, S_DQ_ESC, S_POUND, S_PI,
		S_INC_C, S_INC_L, S_INC_U, S_INC_D, S_INC_E, S_INC_WS,
		S_INC_QNAME, S_INC_ANAME,
		S_IF, S_IF_N, S_IF_E, S_IF_F, S_IFDEF,
		S_C_O, S_C_N, S_C_F, S_C_U,
		S_D_E, S_D_B, S_D_U, S_D_G, S_D_U2,
		S_WORD_FIRST, S_WORD
	} scan_state_t;

	// dispatch of a byte seen in the start state
	function automatic scan_state_t from_start(input logic [BYTE_W-1:0] c);
		scan_state_t r;
		if (c == CH_SLASH)       r = S_SLASH;
		else if (c == CH_SQUOTE) r = S_SQ;
		else if (c == CH_DQUOTE) r = S_DQ;
		else if (c == CH_POUND)  r = S_POUND;
		else                     r = S_START;
		return r;
	endfunction

	// on a directive line only newline ends the line
	function automatic scan_state_t line_again(input logic [BYTE_W-1:0] c);
		return (c == CH_NL) ? S_START : S_IFDEF;
	endfunction

	function automatic logic is_blank(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic logic word_char(input logic [BYTE_W-1:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || (c == CH_UNDER);
	endfunction

	// byte stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// scanner state
	scan_state_t            state_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] mark_q;
	logic [LENGTH_BITS-1:0]   run_q;
	logic                     suppress_q;

	// result register
	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [START_W-1:0]  start_q;
	logic [LENGTH_W-1:0] length_q;

	// next-state logic
	scan_state_t              ns;
	logic [POSITION_BITS-1:0] pos_nxt;
	logic [POSITION_BITS-1:0] mark_d;
	logic [LENGTH_BITS-1:0]   run_d;
	logic [LENGTH_BITS-1:0]   run_inc;
	logic                     emit;
	logic [KIND_W-1:0]        kind_d;
	logic                     advance;

	assign advance = valid_s1 && (!out_valid_q || events.ready);
	assign chars.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign events.valid       = out_valid_q;
	assign events.event_kind  = kind_q;
	assign events.name_start  = start_q;
	assign events.name_length = length_q;

	// saturating counters
	assign pos_nxt = (pos_q == {POSITION_BITS{1'b1}}) ? pos_q : pos_q + POSITION_BITS'(1);
	assign run_inc = (run_q == {LENGTH_BITS{1'b1}}) ? run_q : run_q + LENGTH_BITS'(1);

	// one scan step on the staged byte
	always_comb begin
		ns     = S_START;
		mark_d = mark_q;
		run_d  = run_q;
		emit   = 1'b0;
		kind_d = KIND_QUOTED;
		unique case (state_q)
			S_START: ns = from_start(byte_s1);
			S_SLASH: begin
				if (byte_s1 == CH_SLASH)     ns = S_LINE;
				else if (byte_s1 == CH_STAR) ns = S_BLOCK;
				else                         ns = from_start(byte_s1);
			end
			S_LINE: begin
				if (byte_s1 == CH_NL)          ns = S_START;
				else if (byte_s1 == CH_BSLASH) ns = S_LINE_ESC;
				else                           ns = S_LINE;
			end
			S_LINE_ESC: ns = S_LINE;
			S_BLOCK: ns = (byte_s1 == CH_STAR) ? S_BLOCK_STAR : S_BLOCK;
			S_BLOCK_STAR: begin
				if (byte_s1 == CH_SLASH)     ns = S_START;
				else if (byte_s1 == CH_STAR) ns = S_BLOCK_STAR;
				else                         ns = S_BLOCK;
			end
			S_SQ: begin
				if (byte_s1 == CH_SQUOTE)      ns = S_START;
				else if (byte_s1 == CH_BSLASH) ns = S_SQ_ESC;
				else                           ns = S_SQ;
			end
			S_SQ_ESC: ns = S_SQ;
			S_DQ: begin
				if (byte_s1 == CH_DQUOTE)      ns = S_START;
				else if (byte_s1 == CH_BSLASH) ns = S_DQ_ESC;
				else                           ns = S_DQ;
			end
			S_DQ_ESC: ns = S_DQ;
			S_POUND: begin
				if (is_blank(byte_s1))  ns = S_POUND;
				else if (byte_s1 == "i") ns = S_PI;
				else                     ns = from_start(byte_s1);
			end
			S_PI: begin
				if (byte_s1 == "f")      ns = suppress_q ? S_START : S_IF;
				else if (byte_s1 == "n") ns = S_INC_C;
				else                     ns = from_start(byte_s1);
			end
			S_INC_C: ns = (byte_s1 == "c") ? S_INC_L : from_start(byte_s1);
			S_INC_L: ns = (byte_s1 == "l") ? S_INC_U : from_start(byte_s1);
			S_INC_U: ns = (byte_s1 == "u") ? S_INC_D : from_start(byte_s1);
			S_INC_D: ns = (byte_s1 == "d") ? S_INC_E : from_start(byte_s1);
			S_INC_E: ns = (byte_s1 == "e") ? S_INC_WS : from_start(byte_s1);
			S_INC_WS: begin
				if (byte_s1 == CH_NL) begin
					ns = S_START;
				end else if (is_blank(byte_s1)) begin
					ns = S_INC_WS;
				end else if (byte_s1 == CH_DQUOTE || byte_s1 == CH_LT) begin
					ns     = (byte_s1 == CH_DQUOTE) ? S_INC_QNAME : S_INC_ANAME;
					mark_d = pos_nxt;
					run_d  = '0;
				end else begin
					ns = from_start(byte_s1);
				end
			end
			S_INC_QNAME, S_INC_ANAME: begin
				if (byte_s1 == CH_NL) begin
					ns = S_START;
				end else if (byte_s1 == ((state_q == S_INC_QNAME) ? CH_DQUOTE : CH_GT)) begin
					emit   = 1'b1;
					kind_d = (state_q == S_INC_QNAME) ? KIND_QUOTED : KIND_ANGLE;
					ns     = S_START;
				end else begin
					run_d = run_inc;
					ns    = state_q;
				end
			end
			S_IF: begin
				if (byte_s1 == CH_NL)       ns = S_START;
				else if (is_blank(byte_s1)) ns = S_IFDEF;
				else if (byte_s1 == "n")    ns = S_IF_N;
				else if (byte_s1 == "d")    ns = S_IF_E;
				else                        ns = from_start(byte_s1);
			end
			S_IF_N: ns = (byte_s1 == "d") ? S_IF_E : from_start(byte_s1);
			S_IF_E: ns = (byte_s1 == "e") ? S_IF_F : from_start(byte_s1);
			S_IF_F: ns = (byte_s1 == "f") ? S_IFDEF : from_start(byte_s1);
			S_IFDEF: begin
				if (byte_s1 == "C" || byte_s1 == "D") begin
					ns     = (byte_s1 == "C") ? S_C_O : S_D_E;
					mark_d = pos_q;
					run_d  = LENGTH_BITS'(1);
				end else begin
					ns = line_again(byte_s1);
				end
			end
			// CONF_ prefix
			S_C_O: begin
				if (byte_s1 == "O") begin run_d = run_inc; ns = S_C_N; end
				else ns = line_again(byte_s1);
			end
			S_C_N: begin
				if (byte_s1 == "N") begin run_d = run_inc; ns = S_C_F; end
				else ns = line_again(byte_s1);
			end
			S_C_F: begin
				if (byte_s1 == "F") begin run_d = run_inc; ns = S_C_U; end
				else ns = line_again(byte_s1);
			end
			S_C_U: begin
				if (byte_s1 == CH_UNDER) begin run_d = run_inc; ns = S_WORD_FIRST; end
				else ns = line_again(byte_s1);
			end
			// DEBUG_ prefix
			S_D_E: begin
				if (byte_s1 == "E") begin run_d = run_inc; ns = S_D_B; end
				else ns = line_again(byte_s1);
			end
			S_D_B: begin
				if (byte_s1 == "B") begin run_d = run_inc; ns = S_D_U; end
				else ns = line_again(byte_s1);
			end
			S_D_U: begin
				if (byte_s1 == "U") begin run_d = run_inc; ns = S_D_G; end
				else ns = line_again(byte_s1);
			end
			S_D_G: begin
				if (byte_s1 == "G") begin run_d = run_inc; ns = S_D_U2; end
				else ns = line_again(byte_s1);
			end
			S_D_U2: begin
				if (byte_s1 == CH_UNDER) begin run_d = run_inc; ns = S_WORD_FIRST; end
				else ns = line_again(byte_s1);
			end
			// word body, reported once at least one character follows the prefix
			S_WORD_FIRST, S_WORD: begin
				if (word_char(byte_s1)) begin
					run_d = run_inc;
					ns    = S_WORD;
				end else begin
					if (state_q == S_WORD) begin
						emit   = 1'b1;
						kind_d = KIND_WORD;
					end
					ns = line_again(byte_s1);
				end
			end
			default: ns = S_START;
		endcase
	end

	// byte stage, scanner state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= S_START;
			pos_q       <= '0;
			mark_q      <= '0;
			run_q       <= '0;
			suppress_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				suppress_q <= cfg.suppress_conf;
			end

			if (chars.valid && chars.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				out_valid_q <= emit;
				if (last_s1) begin
					state_q <= S_START;
					pos_q   <= '0;
					mark_q  <= '0;
					run_q   <= '0;
				end else begin
					state_q <= ns;
					pos_q   <= pos_nxt;
					mark_q  <= mark_d;
					run_q   <= run_d;
				end
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			byte_s1 <= chars.data_byte;
			last_s1 <= chars.last_byte;
		end
		if (advance && emit) begin
			kind_q   <= kind_d;
			start_q  <= START_W'(mark_q);
			length_q <= LENGTH_W'(run_q);
		end
	end

endmodule

// ===== hw/rtl/cds_checker.sv =====
`include "c_directive_scanner_defines.svh"

module cds_checker
	import cds_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [KIND_W-1:0]   event_kind,
	input logic [START_W-1:0]  name_start,
	input logic [LENGTH_W-1:0] name_length
);

	// a stalled event stays offered unchanged
	`CDS_ASSERT_NXT(a_evt_hold, out_valid && !out_ready, out_valid && $stable(event_kind) && $stable(name_start) && $stable(name_length), "event dropped or changed while stalled")

	// a fresh event follows a request taken on the chars channel before it
	`CDS_ASSERT_IMP(a_evt_cause, $rose(out_valid), $past(in_valid && in_ready, 2), "event without a preceding request")

	// a word carries its prefix and at least one more character
	`CDS_ASSERT_IMP(a_word_len, out_valid && event_kind == KIND_WORD, name_length >= WORD_MIN_LEN, "word event shorter than its prefix")

	// an include name cannot start before the directive and its opening quote or angle bracket
	`CDS_ASSERT_IMP(a_inc_start, out_valid && (event_kind == KIND_QUOTED || event_kind == KIND_ANGLE), name_start >= INC_MIN_START, "include name starts too early")

endmodule

bind c_directive_scanner cds_checker u_cds_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (chars.valid),
	.in_ready    (chars.ready),
	.out_valid   (events.valid),
	.out_ready   (events.ready),
	.event_kind  (events.event_kind),
	.name_start  (events.name_start),
	.name_length (events.name_length)
);
